[rtl/core/trwm_pkg.sv]
`default_nettype none

package trwm_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_START,
    ST_STEP,
    ST_READ,
    ST_TEST,
    ST_FINISH
  } state_e;

  // Register indexes on the configuration port (byte address divided by four).
  localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_REACH_LIMIT = 2'd2;
  localparam logic [1:0] REG_UNBREAKABLE = 2'd3;

  // Register reset values.
  localparam logic [6:0] RST_MAP_WIDTH   = 7'd64;
  localparam logic [6:0] RST_MAP_HEIGHT  = 7'd64;
  localparam logic [5:0] RST_REACH_LIMIT = 6'd3;
  localparam logic [7:0] RST_UNBREAKABLE = 8'd5;

  // Distances are unsigned Q4.20 and saturate at all ones.
  localparam int unsigned DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

  // The reciprocal 2^30 / mag only fits in 24 bits for mag above 64. Long
  // division then starts with the partial remainder 2^30 >> 24 = 64 and needs
  // 24 quotient bits, two per cycle.
  localparam logic [15:0] SAT_MAG      = 16'd64;
  localparam logic [15:0] DIV_INIT_REM = 16'd64;
  localparam int unsigned DIV_CNT_W    = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd11;

  // One tile in Q1.10.
  localparam logic [10:0] FRAC_ONE = 11'd1024;

  // Signed cell coordinates, wide enough for any map size and one step beyond.
  localparam int unsigned COORD_W = 10;

endpackage

`default_nettype wire

[rtl/core/tile_ray_walk_and_mine.sv]
`default_nettype none

// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: action; tdata: tile_col, tile_row, tile_value,
//                      pos_x, pos_y, dir_x, dir_y
// m_axis    out        tuser: did_mine; tdata: mined_value, hit_col, hit_row
// APB       in         map_width, map_height, reach_limit, unbreakable_tile
//                      at byte addresses 0, 4, 8 and 12
//
// A mining ray runs the shared radix-4 divider for the two reciprocals, then the
// shared multiplier, then walks at most reach_limit grid steps, each through the
// states STEP, READ and TEST on the tile memory.
// After reset the tile memory is swept to zero, one entry per cycle, over all
// MAP_SIDE*MAP_SIDE entries; no transaction is accepted until the sweep ends.
// The finished result sits in an output register, so a stalled m_axis holds
// the next item only in its FINISH state.

module tile_ray_walk_and_mine #(
  parameter int unsigned MAP_SIDE  = 64,
  parameter int unsigned TILE_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input transactions.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tile_col[5:0], tile_row[11:6], tile_value[19:12], pos_x[35:20],
  // pos_y[51:36], dir_x[67:52], dir_y[83:68], zero fill[87:84]
  input  wire logic [87:0] s_axis_tdata,
  // action[0]
  input  wire logic        s_axis_tuser,
  // Result transactions.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mined_value[7:0], hit_col[13:8], hit_row[19:14], zero fill[23:20]
  output logic [23:0]      m_axis_tdata,
  // did_mine[0]
  output logic             m_axis_tuser,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CMP_W = (TILE_BITS > 8) ? TILE_BITS : 8;
  localparam int unsigned CW    = trwm_pkg::COORD_W;
  localparam int unsigned DW    = trwm_pkg::DIST_W;

  // Tile memory with a registered read port.
  logic [TILE_BITS-1:0] mem_q [DEPTH];
  logic [TILE_BITS-1:0] rd_q;

  trwm_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [6:0] map_width_q, map_height_q;
  logic [5:0] reach_limit_q;
  logic [7:0] unbreakable_q;

  // Sequencer and datapath registers.
  logic [AW-1:0]               clr_addr_q;
  logic [trwm_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                        phase_q;
  logic [5:0]                  n_q;
  logic [15:0]                 rem_q;
  logic [DW-1:0]               quo_q;
  logic [15:0]                 mag_x_q, mag_y_q;
  logic [10:0]                 f_x_q, f_y_q;
  logic [DW-1:0]               dd_x_q, dd_y_q, side_x_q, side_y_q;
  logic signed [CW-1:0]        cx_q, cy_q;
  logic                        neg_x_q, neg_y_q;
  logic [7:0]                  res_value_q;
  logic                        res_mine_q;
  logic [5:0]                  res_col_q, res_row_q;
  logic                        out_valid_q;
  logic [7:0]                  out_value_q;
  logic                        out_mine_q;
  logic [5:0]                  out_col_q, out_row_q;

  // Input fields.
  logic [5:0]  in_col, in_row;
  logic [7:0]  in_value;
  logic [15:0] in_px, in_py, in_dx, in_dy;

  assign in_col   = s_axis_tdata[5:0];
  assign in_row   = s_axis_tdata[11:6];
  assign in_value = s_axis_tdata[19:12];
  assign in_px    = s_axis_tdata[35:20];
  assign in_py    = s_axis_tdata[51:36];
  assign in_dx    = s_axis_tdata[67:52];
  assign in_dy    = s_axis_tdata[83:68];

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Map size in use: a register above MAP_SIDE acts as MAP_SIDE.
  logic signed [CW-1:0] eff_w, eff_h;
  always_comb begin
    eff_w = ({3'b0, map_width_q} > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : {3'b0, map_width_q};
    eff_h = ({3'b0, map_height_q} > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : {3'b0, map_height_q};
  end

  // Shared divider: two restoring steps of 2^30 / mag per cycle.
  logic [15:0]   mag_sel, r1, r2;
  logic [16:0]   s1, s2;
  logic          ge1, ge2, mag_small;
  logic [DW-1:0] quo_next, recip;
  always_comb begin
    mag_sel   = phase_q ? mag_y_q : mag_x_q;
    s1        = {rem_q, 1'b0};
    ge1       = s1 >= {1'b0, mag_sel};
    r1        = ge1 ? 16'(s1 - {1'b0, mag_sel}) : s1[15:0];
    s2        = {r1, 1'b0};
    ge2       = s2 >= {1'b0, mag_sel};
    r2        = ge2 ? 16'(s2 - {1'b0, mag_sel}) : s2[15:0];
    quo_next  = {quo_q[DW-3:0], ge1, ge2};
    mag_small = mag_sel <= trwm_pkg::SAT_MAG;
    recip     = mag_small ? trwm_pkg::DIST_MAX : quo_next;
  end

  // Shared multiplier for the starting side distances.
  logic [34:0]   prod;
  logic [DW-1:0] side_start;
  always_comb begin
    prod       = 35'(phase_q ? f_y_q : f_x_q) * 35'(phase_q ? dd_y_q : dd_x_q);
    side_start = prod[34] ? trwm_pkg::DIST_MAX : prod[33:10];
  end

  // Shared saturating adder for one grid step; ties step in y.
  logic          step_x;
  logic [DW:0]   step_sum;
  logic [DW-1:0] side_next;
  always_comb begin
    step_x    = side_x_q < side_y_q;
    step_sum  = {1'b0, step_x ? side_x_q : side_y_q} + {1'b0, step_x ? dd_x_q : dd_y_q};
    side_next = step_sum[DW] ? trwm_pkg::DIST_MAX : step_sum[DW-1:0];
  end

  // Cell checks.
  logic start_out, cell_out, tile_set, breakable, out_free, wr_in_range;
  always_comb begin
    start_out   = (cx_q >= eff_w) || (cy_q >= eff_h);
    cell_out    = cx_q[CW-1] || cy_q[CW-1] || (cx_q >= eff_w) || (cy_q >= eff_h);
    tile_set    = rd_q != '0;
    breakable   = CMP_W'(rd_q) != CMP_W'(unbreakable_q);
    out_free    = !out_valid_q || m_axis_tready;
    wr_in_range = ({4'b0, in_col} < CW'(MAP_SIDE)) && ({4'b0, in_row} < CW'(MAP_SIDE));
  end

  logic [AW-1:0] cell_addr, wr_addr;
  assign cell_addr = AW'(cy_q) * AW'(MAP_SIDE) + AW'(cx_q);
  assign wr_addr   = AW'(in_row) * AW'(MAP_SIDE) + AW'(in_col);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      trwm_pkg::ST_CLEAR: begin
        if (clr_addr_q == AW'(DEPTH - 1)) state_d = trwm_pkg::ST_IDLE;
      end
      trwm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = s_axis_tuser ? trwm_pkg::ST_DIV : trwm_pkg::ST_FINISH;
      end
      trwm_pkg::ST_DIV: begin
        if (cnt_q == trwm_pkg::DIV_LAST && phase_q) state_d = trwm_pkg::ST_MUL;
      end
      trwm_pkg::ST_MUL: begin
        if (phase_q) state_d = trwm_pkg::ST_START;
      end
      trwm_pkg::ST_START: begin
        state_d = start_out ? trwm_pkg::ST_FINISH : trwm_pkg::ST_STEP;
      end
      trwm_pkg::ST_STEP: begin
        state_d = (n_q == reach_limit_q) ? trwm_pkg::ST_FINISH : trwm_pkg::ST_READ;
      end
      trwm_pkg::ST_READ: begin
        state_d = cell_out ? trwm_pkg::ST_FINISH : trwm_pkg::ST_TEST;
      end
      trwm_pkg::ST_TEST: begin
        state_d = tile_set ? trwm_pkg::ST_FINISH : trwm_pkg::ST_STEP;
      end
      trwm_pkg::ST_FINISH: begin
        if (out_free) state_d = trwm_pkg::ST_IDLE;
      end
      default: state_d = trwm_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs: handshake and memory port controls.
  logic                 mem_we, rd_en, load_out;
  logic [AW-1:0]        mem_wa;
  logic [TILE_BITS-1:0] mem_wd;
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = cell_addr;
    mem_wd        = rd_q - 1'b1;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      trwm_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_q;
        mem_wd = '0;
      end
      trwm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_we        = s_axis_tvalid && !s_axis_tuser && wr_in_range;
        mem_wa        = wr_addr;
        mem_wd        = TILE_BITS'(in_value);
      end
      trwm_pkg::ST_READ: begin
        rd_en = !cell_out;
      end
      trwm_pkg::ST_TEST: begin
        mem_we = tile_set && breakable;
      end
      trwm_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[cell_addr];
  end

  // Configuration writes.
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      trwm_pkg::REG_MAP_WIDTH:   prdata = {25'b0, map_width_q};
      trwm_pkg::REG_MAP_HEIGHT:  prdata = {25'b0, map_height_q};
      trwm_pkg::REG_REACH_LIMIT: prdata = {26'b0, reach_limit_q};
      trwm_pkg::REG_UNBREAKABLE: prdata = {24'b0, unbreakable_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= trwm_pkg::RST_MAP_WIDTH;
      map_height_q  <= trwm_pkg::RST_MAP_HEIGHT;
      reach_limit_q <= trwm_pkg::RST_REACH_LIMIT;
      unbreakable_q <= trwm_pkg::RST_UNBREAKABLE;
    end else if (cfg_we) begin
      case (paddr[3:2])
        trwm_pkg::REG_MAP_WIDTH:   map_width_q   <= pwdata[6:0];
        trwm_pkg::REG_MAP_HEIGHT:  map_height_q  <= pwdata[6:0];
        trwm_pkg::REG_REACH_LIMIT: reach_limit_q <= pwdata[5:0];
        trwm_pkg::REG_UNBREAKABLE: unbreakable_q <= pwdata[7:0];
        default:                   map_width_q   <= map_width_q;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trwm_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == trwm_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (accept) begin
        cnt_q   <= '0;
        phase_q <= 1'b0;
      end else if (state_q == trwm_pkg::ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == trwm_pkg::DIV_LAST) begin
          cnt_q   <= '0;
          phase_q <= !phase_q;
        end
      end else if (state_q == trwm_pkg::ST_MUL) begin
        phase_q <= !phase_q;
      end
      if (state_q == trwm_pkg::ST_START) n_q <= '0;
      else if (state_q == trwm_pkg::ST_STEP) n_q <= n_q + 1'b1;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      trwm_pkg::ST_IDLE: begin
        if (accept) begin
          res_value_q <= '0;
          res_mine_q  <= 1'b0;
          res_col_q   <= '0;
          res_row_q   <= '0;
          rem_q       <= trwm_pkg::DIV_INIT_REM;
          quo_q       <= '0;
          mag_x_q     <= in_dx[15] ? 16'(-in_dx) : in_dx;
          mag_y_q     <= in_dy[15] ? 16'(-in_dy) : in_dy;
          neg_x_q     <= in_dx[15];
          neg_y_q     <= in_dy[15];
          f_x_q       <= in_dx[15] ? {1'b0, in_px[9:0]} : trwm_pkg::FRAC_ONE - {1'b0, in_px[9:0]};
          f_y_q       <= in_dy[15] ? {1'b0, in_py[9:0]} : trwm_pkg::FRAC_ONE - {1'b0, in_py[9:0]};
          cx_q        <= CW'(in_px[15:10]);
          cy_q        <= CW'(in_py[15:10]);
        end
      end
      trwm_pkg::ST_DIV: begin
        rem_q <= r2;
        quo_q <= quo_next;
        if (cnt_q == trwm_pkg::DIV_LAST) begin
          rem_q <= trwm_pkg::DIV_INIT_REM;
          quo_q <= '0;
          if (phase_q) dd_y_q <= recip;
          else         dd_x_q <= recip;
        end
      end
      trwm_pkg::ST_MUL: begin
        if (phase_q) side_y_q <= side_start;
        else         side_x_q <= side_start;
      end
      trwm_pkg::ST_STEP: begin
        if (n_q != reach_limit_q) begin
          if (step_x) begin
            side_x_q <= side_next;
            cx_q     <= neg_x_q ? cx_q - 1'b1 : cx_q + 1'b1;
          end else begin
            side_y_q <= side_next;
            cy_q     <= neg_y_q ? cy_q - 1'b1 : cy_q + 1'b1;
          end
        end
      end
      trwm_pkg::ST_TEST: begin
        if (tile_set && breakable) begin
          res_value_q <= 8'(rd_q);
          res_mine_q  <= 1'b1;
          res_col_q   <= cx_q[5:0];
          res_row_q   <= cy_q[5:0];
        end
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= res_value_q;
      out_mine_q  <= res_mine_q;
      out_col_q   <= res_col_q;
      out_row_q   <= res_row_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_row_q, out_col_q, out_value_q};
  assign m_axis_tuser  = out_mine_q;

endmodule

`default_nettype wire
